// ===== rtl/jad_pkg.sv =====
// Shared types and constants for the joystick angle block.
// No dependencies; imported by every module of the block but the queue.
package jad_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int TABLE_LEN = 24;
	localparam int FRAC_BITS = 16;
	localparam int AXIS_W = 12;
	localparam int DEAD_W = 10;
	localparam int LIM_W = 11;
	localparam int ANG_W = 9;
	localparam int U_W = 32;
	localparam int Z_W = 27;
	localparam int DEG_W = Z_W - FRAC_BITS;
	localparam int MID_DEPTH = 4;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// register indexes (byte address = 4 * index)
	localparam logic [2:0] REG_X_BELOW = 3'd0;
	localparam logic [2:0] REG_X_ABOVE = 3'd1;
	localparam logic [2:0] REG_Y_BELOW = 3'd2;
	localparam logic [2:0] REG_Y_ABOVE = 3'd3;
	localparam logic [2:0] REG_CLAMP   = 3'd4;

	localparam logic [DEAD_W-1:0] X_BELOW_RST = DEAD_W'(40);
	localparam logic [DEAD_W-1:0] X_ABOVE_RST = DEAD_W'(41);
	localparam logic [DEAD_W-1:0] Y_BELOW_RST = DEAD_W'(28);
	localparam logic [DEAD_W-1:0] Y_ABOVE_RST = DEAD_W'(29);
	localparam logic [LIM_W-1:0]  CLAMP_RST   = LIM_W'(512);

	// starting rotation applied in the front
	localparam logic [1:0] ZROT_NONE  = 2'd0;
	localparam logic [1:0] ZROT_POS90 = 2'd1;
	localparam logic [1:0] ZROT_NEG90 = 2'd2;

	localparam logic [ANG_W-1:0] ANG_0   = ANG_W'(0);
	localparam logic [ANG_W-1:0] ANG_90  = ANG_W'(90);
	localparam logic [ANG_W-1:0] ANG_180 = ANG_W'(180);
	localparam logic [ANG_W-1:0] ANG_270 = ANG_W'(270);

	localparam int DEG_FULL = 360;
	localparam logic signed [Z_W-1:0] Z_90  = Z_W'(90 * (1 << FRAC_BITS));
	localparam logic signed [Z_W-1:0] Z_360 = Z_W'(DEG_FULL * (1 << FRAC_BITS));

	// atan(2^-i) in degrees, Q.16, rounded to nearest
	localparam logic [21:0] ATAN_DEG_Q16 [TABLE_LEN] = '{
		22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
		22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
		22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
		22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
	};

	typedef struct packed {
		logic [DEAD_W-1:0] x_below;
		logic [DEAD_W-1:0] x_above;
		logic [DEAD_W-1:0] y_below;
		logic [DEAD_W-1:0] y_above;
		logic [LIM_W-1:0]  clamp;
	} cfg_t;

	// classified item handed from the front to the CORDIC
	typedef struct packed {
		logic                     special;
		logic [ANG_W-1:0]         angle;
		logic [1:0]               zrot;
		logic signed [AXIS_W-1:0] u0;
		logic signed [AXIS_W-1:0] v0;
	} work_t;

endpackage

// ===== rtl/jad_fifo.sv =====
// Small register queue, used between front and CORDIC and on the result side.
// Depends on nothing but its parameters.
module jad_fifo #(
	parameter int DEPTH = 4,
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/jad_front.sv =====
// Front end: dead zone, clamp and quadrant classification of one sample.
// Depends on jad_pkg.
module jad_front
	import jad_pkg::*;
(
	input  cfg_t                     cfg,
	input  logic signed [AXIS_W-1:0] axis_x,
	input  logic signed [AXIS_W-1:0] axis_y,
	output work_t                    item
);

	function automatic logic signed [AXIS_W-1:0] shape(
		input logic signed [AXIS_W-1:0] v,
		input logic [DEAD_W-1:0]        below,
		input logic [DEAD_W-1:0]        above,
		input logic [LIM_W-1:0]         lim
	);
		logic signed [AXIS_W:0] vs;
		logic signed [AXIS_W:0] l;
		logic signed [AXIS_W:0] nl;
		logic signed [AXIS_W:0] lo;
		logic signed [AXIS_W:0] hi;
		logic signed [AXIS_W-1:0] r;
		vs = {v[AXIS_W-1], v};
		l  = $signed({2'b00, lim});
		nl = -l;
		lo = -$signed({3'b000, below});
		hi = $signed({3'b000, above});
		// clamp is judged on the raw sample and wins over the dead zone
		if (vs > l) begin
			r = l[AXIS_W-1:0];
		end else if (vs < nl) begin
			r = nl[AXIS_W-1:0];
		end else if (vs > lo && vs < hi) begin
			r = '0;
		end else begin
			r = v;
		end
		return r;
	endfunction

	logic signed [AXIS_W-1:0] x;
	logic signed [AXIS_W-1:0] y;

	assign x = shape(axis_x, cfg.x_below, cfg.x_above, cfg.clamp);
	assign y = shape(axis_y, cfg.y_below, cfg.y_above, cfg.clamp);

	always_comb begin
		item.special = 1'b0;
		item.angle   = ANG_0;
		item.zrot    = ZROT_NONE;
		item.u0      = y;
		item.v0      = x;
		if (x == '0) begin
			item.special = 1'b1;
			item.angle   = (y < 0) ? ANG_180 : ANG_0;
		end else if (y == '0) begin
			item.special = 1'b1;
			item.angle   = (x > 0) ? ANG_90 : ANG_270;
		end else if (y < 0) begin
			// lower half plane: rotate by a quarter turn into the right half
			if (x > 0) begin
				item.zrot = ZROT_POS90;
				item.u0   = x;
				item.v0   = -y;
			end else begin
				item.zrot = ZROT_NEG90;
				item.u0   = -x;
				item.v0   = y;
			end
		end
	end

endmodule

// ===== rtl/jad_cordic.sv =====
// Unrolled vectoring CORDIC, one pipeline stage per iteration, angle in Q.16 degrees.
// Depends on jad_pkg.
module jad_cordic
	import jad_pkg::*;
#(
	parameter int STEPS = CORDIC_STEPS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  work_t            in_item,
	output logic             out_valid,
	output logic [ANG_W-1:0] out_angle
);

	localparam int N = (STEPS > TABLE_LEN) ? TABLE_LEN : STEPS;

	logic signed [U_W-1:0] u_s       [N+1];
	logic signed [U_W-1:0] v_s       [N+1];
	logic signed [Z_W-1:0] z_s       [N+1];
	logic                  special_s [N+1];
	logic [ANG_W-1:0]      spang_s   [N+1];
	logic                  valid_s   [N+1];
	logic [ANG_W-1:0]      angle_q;
	logic                  out_valid_q;

	logic signed [Z_W-1:0] z_wrap;
	logic [DEG_W-1:0]      deg;

	// entry stage: scale by 2^16 and apply the starting rotation
	always_ff @(posedge clk) begin
		u_s[0] <= $signed({{(U_W - AXIS_W - FRAC_BITS){in_item.u0[AXIS_W-1]}},
			in_item.u0, {FRAC_BITS{1'b0}}});
		v_s[0] <= $signed({{(U_W - AXIS_W - FRAC_BITS){in_item.v0[AXIS_W-1]}},
			in_item.v0, {FRAC_BITS{1'b0}}});
		case (in_item.zrot)
			ZROT_POS90: z_s[0] <= Z_90;
			ZROT_NEG90: z_s[0] <= -Z_90;
			default:    z_s[0] <= '0;
		endcase
		special_s[0] <= in_item.special;
		spang_s[0]   <= in_item.angle;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else begin
			valid_s[0] <= in_valid;
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_iter
		localparam logic signed [Z_W-1:0] ATAN_K = Z_W'(ATAN_DEG_Q16[k]);

		always_ff @(posedge clk) begin
			if (!v_s[k][U_W-1]) begin
				u_s[k+1] <= u_s[k] + (v_s[k] >>> k);
				v_s[k+1] <= v_s[k] - (u_s[k] >>> k);
				z_s[k+1] <= z_s[k] + ATAN_K;
			end else begin
				u_s[k+1] <= u_s[k] - (v_s[k] >>> k);
				v_s[k+1] <= v_s[k] + (u_s[k] >>> k);
				z_s[k+1] <= z_s[k] - ATAN_K;
			end
			special_s[k+1] <= special_s[k];
			spang_s[k+1]   <= spang_s[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else begin
				valid_s[k+1] <= valid_s[k];
			end
		end
	end

	// wrap into 0..359 and truncate to whole degrees
	always_comb begin
		z_wrap = z_s[N];
		if (z_wrap < 0) begin
			z_wrap = z_wrap + Z_360;
		end
		if (z_wrap < 0) begin
			z_wrap = '0;
		end
		deg = z_wrap[Z_W-1:FRAC_BITS];
		if (deg >= DEG_W'(DEG_FULL)) begin
			deg = deg - DEG_W'(DEG_FULL);
		end
		if (deg >= DEG_W'(DEG_FULL)) begin
			deg = '0;
		end
	end

	always_ff @(posedge clk) begin
		angle_q <= special_s[N] ? spang_s[N] : deg[ANG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= valid_s[N];
		end
	end

	assign out_valid = out_valid_q;
	assign out_angle = angle_q;

endmodule

// ===== rtl/joystick_angle_with_deadzone.sv =====
// Joystick sample to compass angle (0..359 degrees, from +y toward +x) with per-axis
// dead zones and clamp. One sample is accepted per clock while full is low and one
// result leaves per clock while pop is held and empty is low. A pushed sample passes
// through the four-entry front queue, then the unrolled CORDIC pipeline with one
// register stage per iteration plus entry and wrap stages, then the result queue.
// The result queue holds min(CORDIC_STEPS,24) + 4 entries and the CORDIC issues only
// when a slot is reserved there, so the two sides stall independently. Registers sit
// on an APB port at byte address 4 * index.
module joystick_angle_with_deadzone
	import jad_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_W-1:0]        paddr,
	input  logic [DATA_W-1:0]        pwdata,
	output logic [DATA_W-1:0]        prdata,
	output logic                     pready,
	input  logic                     push,
	output logic                     full,
	input  logic signed [AXIS_W-1:0] axis_x,
	input  logic signed [AXIS_W-1:0] axis_y,
	output logic                     empty,
	input  logic                     pop,
	output logic [ANG_W-1:0]         angle_deg
);

	localparam int N_EFF = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
	localparam int OUT_DEPTH = N_EFF + 4;
	localparam int CW = $clog2(OUT_DEPTH + 1);

	cfg_t  cfg_q;
	work_t front_item;
	work_t mid_item;
	logic  mid_full;
	logic  mid_empty;
	logic  issue;
	logic  out_empty;
	logic  out_pop;
	logic  back_valid;
	logic [ANG_W-1:0] back_angle;
	logic [CW-1:0]    credit_q;

	// register port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_below <= X_BELOW_RST;
			cfg_q.x_above <= X_ABOVE_RST;
			cfg_q.y_below <= Y_BELOW_RST;
			cfg_q.y_above <= Y_ABOVE_RST;
			cfg_q.clamp   <= CLAMP_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[4:2])
				REG_X_BELOW: cfg_q.x_below <= pwdata[DEAD_W-1:0];
				REG_X_ABOVE: cfg_q.x_above <= pwdata[DEAD_W-1:0];
				REG_Y_BELOW: cfg_q.y_below <= pwdata[DEAD_W-1:0];
				REG_Y_ABOVE: cfg_q.y_above <= pwdata[DEAD_W-1:0];
				REG_CLAMP:   cfg_q.clamp   <= pwdata[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_X_BELOW: prdata = DATA_W'(cfg_q.x_below);
			REG_X_ABOVE: prdata = DATA_W'(cfg_q.x_above);
			REG_Y_BELOW: prdata = DATA_W'(cfg_q.y_below);
			REG_Y_ABOVE: prdata = DATA_W'(cfg_q.y_above);
			REG_CLAMP:   prdata = DATA_W'(cfg_q.clamp);
			default:     prdata = '0;
		endcase
	end

	jad_front u_front (
		.cfg    (cfg_q),
		.axis_x (axis_x),
		.axis_y (axis_y),
		.item   (front_item)
	);

	jad_fifo #(
		.DEPTH (MID_DEPTH),
		.WIDTH ($bits(work_t))
	) u_mid_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (front_item),
		.full    (mid_full),
		.rd_en   (issue),
		.rd_data (mid_item),
		.empty   (mid_empty)
	);

	assign full = mid_full;

	// credit covers items in the pipeline plus those in the result queue
	assign issue   = !mid_empty && (credit_q < CW'(OUT_DEPTH));
	assign out_pop = pop && !out_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else if (issue && !out_pop) begin
			credit_q <= credit_q + 1'b1;
		end else if (out_pop && !issue) begin
			credit_q <= credit_q - 1'b1;
		end
	end

	jad_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (issue),
		.in_item   (mid_item),
		.out_valid (back_valid),
		.out_angle (back_angle)
	);

	jad_fifo #(
		.DEPTH (OUT_DEPTH),
		.WIDTH (ANG_W)
	) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (back_valid),
		.wr_data (back_angle),
		.full    (),
		.rd_en   (pop),
		.rd_data (angle_deg),
		.empty   (out_empty)
	);

	assign empty = out_empty;

endmodule

// ===== rtl/jad_checker.sv =====
// Port-level checks for the joystick angle block, bound to the top level.
// Depends on jad_pkg and joystick_angle_with_deadzone.
module jad_checker
	import jad_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     psel,
	input logic                     penable,
	input logic                     pwrite,
	input logic [ADDR_W-1:0]        paddr,
	input logic [DATA_W-1:0]        pwdata,
	input logic [DATA_W-1:0]        prdata,
	input logic                     pready,
	input logic                     push,
	input logic                     full,
	input logic signed [AXIS_W-1:0] axis_x,
	input logic signed [AXIS_W-1:0] axis_y,
	input logic                     empty,
	input logic                     pop,
	input logic [ANG_W-1:0]         angle_deg
);

	// queues come out of reset with nothing in them
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> (empty && !full))
		else $error("queues not idle in reset");

	a_push_known: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !$isunknown({axis_x, axis_y}))
		else $error("request carries unknown sample");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (angle_deg < ANG_W'(DEG_FULL)))
		else $error("angle out of range");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(angle_deg)))
		else $error("waiting result changed");

	// a written x_below dead-zone value reads back in the next cycle
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready && paddr[4:2] == REG_X_BELOW)
		##1 (psel && !pwrite && paddr[4:2] == REG_X_BELOW)
		|-> (prdata[DEAD_W-1:0] == $past(pwdata[DEAD_W-1:0])))
		else $error("register readback mismatch");

endmodule

bind joystick_angle_with_deadzone jad_checker u_jad_checker (.*);
